// File: hw/rtl/box_filter_image_downscale_macros.svh
// Assertion macros used by the box filter downscaler back end.
// Users must have clk and rst_n in scope.
`ifndef BOX_FILTER_IMAGE_DOWNSCALE_MACROS_SVH
`define BOX_FILTER_IMAGE_DOWNSCALE_MACROS_SVH

// same-cycle implication
`define BFD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BFD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/bfd_pkg.sv
// Package for the box filter downscaler: widths, codes, queue item type.
// No dependencies.
`timescale 1ns / 1ps
package bfd_pkg;
    localparam int CFG_W     = 13;
    localparam int CH_W      = 8;
    localparam int NUM_CH    = 4;
    localparam int SUM_W     = 32;
    localparam int ACC_W     = 2 * CFG_W + 1;
    localparam int CNT_W     = 2 * (CFG_W + 1);
    localparam int DIV_W     = CNT_W + CH_W;
    localparam int IDX_CFG_W = 8;
    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = 1;
    localparam int Q_CNT_W   = 2;
    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam int DEF_CHANNELS   = 4;

    localparam logic [IDX_CFG_W-1:0] REG_SRC_W = 8'd0;
    localparam logic [IDX_CFG_W-1:0] REG_SRC_H = 8'd1;
    localparam logic [IDX_CFG_W-1:0] REG_DST_W = 8'd2;
    localparam logic [IDX_CFG_W-1:0] REG_DST_H = 8'd3;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ACC,
        BK_DIV,
        BK_DONE
    } bk_state_t;

    typedef struct packed {
        logic [CFG_W-1:0]             slot;
        logic                         first;
        logic                         emit;
        logic                         frame_done;
        logic [CNT_W-1:0]             count;
        logic [NUM_CH-1:0][CH_W-1:0]  pix;
    } item_t;

    function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                    input logic [CFG_W-1:0] hi);
        logic [CFG_W-1:0] r;
        if (v == '0)
            r = CFG_W'(1);
        else if (v > hi)
            r = hi;
        else
            r = v;
        return r;
    endfunction
endpackage

// File: hw/rtl/bfd_if.sv
// Stream and configuration interfaces of the box filter downscaler.
// Depends on bfd_pkg.
`timescale 1ns / 1ps
interface bfd_in_if import bfd_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;
    logic [CH_W-1:0] in_alpha;
    logic            start_of_frame;
    modport source (output valid, in_red, in_green, in_blue, in_alpha, start_of_frame,
                    input ready);
    modport sink (input valid, in_red, in_green, in_blue, in_alpha, start_of_frame,
                  output ready);
endinterface

interface bfd_out_if import bfd_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic [CH_W-1:0] out_alpha;
    logic            frame_done;
    modport source (output valid, out_red, out_green, out_blue, out_alpha, frame_done,
                    input ready);
    modport sink (input valid, out_red, out_green, out_blue, out_alpha, frame_done,
                  output ready);
endinterface

interface bfd_cfg_if import bfd_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [IDX_CFG_W-1:0] index;
    logic [CFG_W-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/bfd_front.sv
// Front end: config registers, position tracking, window classification.
// Depends on bfd_pkg and bfd_if.
`timescale 1ns / 1ps
module bfd_front import bfd_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic        clk,
    input  logic        rst_n,
    bfd_in_if.sink      pix_in,
    bfd_cfg_if.sink     cfg,
    output logic        q_push,
    output item_t       q_item,
    input  logic        q_full
);
    localparam int MaxWCfg = (MAX_WIDTH > 8191) ? 8191 : MAX_WIDTH;
    localparam int MaxHCfg = (MAX_HEIGHT > 8191) ? 8191 : MAX_HEIGHT;

    logic [CFG_W-1:0] src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;
    logic             restart_reg;
    logic [CFG_W-1:0] sc_reg, sr_reg, tc_reg, tr_reg, cw_reg, rh_reg;
    logic [ACC_W-1:0] acol_reg, bcol_reg, arow_reg, brow_reg;
    logic             cfirst_reg, rfirst_reg;

    logic [CFG_W-1:0] sc_next, sr_next, tc_next, tr_next, cw_next, rh_next;
    logic [ACC_W-1:0] acol_next, bcol_next, arow_next, brow_next;
    logic             cfirst_next, rfirst_next;

    logic [CFG_W-1:0] ew, eh, etw, eth;
    logic [CFG_W-1:0] sc, sr, tc, tr, cw, rh;
    logic [ACC_W-1:0] acol, bcol, arow, brow;
    logic             cfirst, rfirst, restart, accept, col_last, row_last, row_end, col_end;
    logic [CFG_W:0]   cw1, rh1;

    assign cfg.ready    = 1'b1;
    assign pix_in.ready = !q_full;
    assign accept       = pix_in.valid && !q_full;

    assign ew  = clamp_size(src_w_reg, CFG_W'(MaxWCfg));
    assign eh  = clamp_size(src_h_reg, CFG_W'(MaxHCfg));
    assign etw = clamp_size(dst_w_reg, ew);
    assign eth = clamp_size(dst_h_reg, eh);

    always_comb
    begin
        restart = restart_reg || pix_in.start_of_frame;
        sc     = restart ? '0 : sc_reg;
        sr     = restart ? '0 : sr_reg;
        tc     = restart ? '0 : tc_reg;
        tr     = restart ? '0 : tr_reg;
        cw     = restart ? '0 : cw_reg;
        rh     = restart ? '0 : rh_reg;
        acol   = restart ? ACC_W'(ew)  : acol_reg;
        bcol   = restart ? ACC_W'(etw) : bcol_reg;
        arow   = restart ? ACC_W'(eh)  : arow_reg;
        brow   = restart ? ACC_W'(eth) : brow_reg;
        cfirst = restart ? 1'b1 : cfirst_reg;
        rfirst = restart ? 1'b1 : rfirst_reg;

        col_last = acol < (bcol + ACC_W'(etw));
        row_last = arow < (brow + ACC_W'(eth));
        row_end  = ({1'b0, sc} + 1'b1) >= {1'b0, ew};
        col_end  = ({1'b0, sr} + 1'b1) >= {1'b0, eh};
        cw1      = {1'b0, cw} + 1'b1;
        rh1      = {1'b0, rh} + 1'b1;

        q_push           = accept;
        q_item.slot      = tc;
        q_item.first     = cfirst && rfirst;
        q_item.emit      = col_last && row_last;
        q_item.frame_done = (({1'b0, tc} + 1'b1) == {1'b0, etw})
                         && (({1'b0, tr} + 1'b1) == {1'b0, eth});
        q_item.count     = cw1 * rh1;
        q_item.pix       = {pix_in.in_alpha, pix_in.in_blue, pix_in.in_green, pix_in.in_red};

        sc_next = sc; sr_next = sr; tc_next = tc; tr_next = tr;
        cw_next = cw; rh_next = rh;
        acol_next = acol; bcol_next = bcol; arow_next = arow; brow_next = brow;
        cfirst_next = cfirst; rfirst_next = rfirst;
        if (row_end)
        begin
            sc_next     = '0;
            tc_next     = '0;
            cw_next     = '0;
            cfirst_next = 1'b1;
            acol_next   = ACC_W'(ew);
            bcol_next   = ACC_W'(etw);
            if (col_end)
            begin
                sr_next     = '0;
                tr_next     = '0;
                rh_next     = '0;
                rfirst_next = 1'b1;
                arow_next   = ACC_W'(eh);
                brow_next   = ACC_W'(eth);
            end
            else
            begin
                sr_next   = sr + 1'b1;
                brow_next = brow + ACC_W'(eth);
                if (row_last)
                begin
                    tr_next     = tr + 1'b1;
                    arow_next   = arow + ACC_W'(eh);
                    rh_next     = '0;
                    rfirst_next = 1'b1;
                end
                else
                begin
                    rh_next     = rh + 1'b1;
                    rfirst_next = 1'b0;
                end
            end
        end
        else
        begin
            sc_next   = sc + 1'b1;
            bcol_next = bcol + ACC_W'(etw);
            if (col_last)
            begin
                tc_next     = tc + 1'b1;
                acol_next   = acol + ACC_W'(ew);
                cw_next     = '0;
                cfirst_next = 1'b1;
            end
            else
            begin
                cw_next     = cw + 1'b1;
                cfirst_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg   <= CFG_W'(1);
            src_h_reg   <= CFG_W'(1);
            dst_w_reg   <= CFG_W'(1);
            dst_h_reg   <= CFG_W'(1);
            restart_reg <= 1'b1;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_SRC_W: begin src_w_reg <= cfg.data; restart_reg <= 1'b1; end
                REG_SRC_H: begin src_h_reg <= cfg.data; restart_reg <= 1'b1; end
                REG_DST_W: begin dst_w_reg <= cfg.data; restart_reg <= 1'b1; end
                REG_DST_H: begin dst_h_reg <= cfg.data; restart_reg <= 1'b1; end
                default: ;
            endcase
        end
        else if (accept)
        begin
            restart_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sc_reg <= sc_next; sr_reg <= sr_next; tc_reg <= tc_next; tr_reg <= tr_next;
            cw_reg <= cw_next; rh_reg <= rh_next;
            acol_reg <= acol_next; bcol_reg <= bcol_next;
            arow_reg <= arow_next; brow_reg <= brow_next;
            cfirst_reg <= cfirst_next; rfirst_reg <= rfirst_next;
        end
    end
endmodule

// File: hw/rtl/bfd_queue.sv
// Two-entry queue between front and back ends.
// Depends on bfd_pkg.
`timescale 1ns / 1ps
module bfd_queue import bfd_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output item_t head,
    output logic  empty
);
    item_t              mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_reg, rd_reg;
    logic [Q_CNT_W-1:0] cnt_reg;

    assign full  = cnt_reg == Q_CNT_W'(Q_DEPTH);
    assign empty = cnt_reg == '0;
    assign head  = mem_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_item;
    end
endmodule

// File: hw/rtl/bfd_back.sv
// Back end: column sum memories, accumulate, 8-step divider, output register.
// Depends on bfd_pkg, bfd_if and the assertion macro header.
`timescale 1ns / 1ps
`include "box_filter_image_downscale_macros.svh"
module bfd_back import bfd_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int CHANNELS  = DEF_CHANNELS
) (
    input  logic     clk,
    input  logic     rst_n,
    input  item_t    q_head,
    input  logic     q_empty,
    output logic     q_pop,
    bfd_out_if.source pix_out
);
    localparam int IDX_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    bk_state_t state_reg, state_next;
    item_t     item_reg;
    logic [2:0] step_reg;
    logic       we, load;
    logic [IDX_W-1:0] raddr, waddr;
    logic [NUM_CH-1:0][SUM_W-1:0] rd_data, sum_new, rem_reg;
    logic [NUM_CH-1:0][CH_W-1:0]  quo_reg, out_reg;
    logic       out_valid_reg, out_done_reg;

    assign raddr = IDX_W'(q_head.slot);
    assign waddr = IDX_W'(item_reg.slot);

    genvar c;
    generate
        for (c = 0; c < NUM_CH; c++)
        begin : g_ch
            if (c < CHANNELS)
            begin : g_mem
                logic [SUM_W-1:0] mem [MAX_WIDTH];
                logic [SUM_W-1:0] rd_reg;
                always_ff @(posedge clk)
                begin
                    if (q_pop)
                        rd_reg <= mem[raddr];
                end
                always_ff @(posedge clk)
                begin
                    if (we)
                        mem[waddr] <= sum_new[c];
                end
                assign rd_data[c] = rd_reg;
                assign sum_new[c] = item_reg.first ? SUM_W'(item_reg.pix[c])
                                  : rd_reg + SUM_W'(item_reg.pix[c]);
            end
            else
            begin : g_none
                assign rd_data[c] = '0;
                assign sum_new[c] = rd_data[c];
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= BK_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        we         = 1'b0;
        load       = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    state_next = BK_ACC;
                end
            end
            BK_ACC:
            begin
                we         = 1'b1;
                state_next = item_reg.emit ? BK_DIV : BK_IDLE;
            end
            BK_DIV:
            begin
                if (step_reg == '0)
                    state_next = BK_DONE;
            end
            BK_DONE:
            begin
                if (!out_valid_reg)
                begin
                    load       = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        logic [DIV_W-1:0] dsh;
        logic [DIV_W-1:0] rem_w;
        dsh = DIV_W'(item_reg.count) << step_reg;
        if (q_pop)
            item_reg <= q_head;
        if (state_reg == BK_ACC)
        begin
            step_reg <= 3'd7;
            rem_reg  <= sum_new;
            quo_reg  <= '0;
        end
        else if (state_reg == BK_DIV)
        begin
            step_reg <= step_reg - 1'b1;
            for (int i = 0; i < NUM_CH; i++)
            begin
                rem_w = DIV_W'(rem_reg[i]);
                if (rem_w >= dsh)
                begin
                    rem_reg[i]           <= SUM_W'(rem_w - dsh);
                    quo_reg[i][step_reg] <= 1'b1;
                end
            end
        end
        if (load)
        begin
            out_reg      <= quo_reg;
            out_done_reg <= item_reg.frame_done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= 1'b1;
        else if (pix_out.ready)
            out_valid_reg <= 1'b0;
    end

    assign pix_out.valid      = out_valid_reg;
    assign pix_out.out_red    = out_reg[0];
    assign pix_out.out_green  = out_reg[1];
    assign pix_out.out_blue   = out_reg[2];
    assign pix_out.out_alpha  = out_reg[3];
    assign pix_out.frame_done = out_done_reg;

    `BFD_ASSERT_IMP(a_pop_idle, q_pop, state_reg == BK_IDLE, "queue pop outside idle")
    `BFD_ASSERT_NXT(a_emit_div, state_reg == BK_ACC && item_reg.emit, state_reg == BK_DIV, "emit beat skipped divide")
    `BFD_ASSERT_NXT(a_div_end, state_reg == BK_DIV && step_reg == 3'd0, state_reg == BK_DONE, "divider overran")
    `BFD_ASSERT_IMP(a_load_free, load, !out_valid_reg, "output register overwritten")
endmodule

// File: hw/rtl/box_filter_image_downscale.sv
// Back end: each source beat is popped from the queue and added into the sum memory; a beat
// that completes a destination pixel then goes through the 8-step divider and output load.
// The back end takes a new source beat only once the last one is done, paced by the sum memory
// read-modify-write, the radix-2 divider and the wait for a free output register.
// Front accepts 1 beat per cycle into a 2-entry queue while the queue is not full.
// Reset: async active low; sizes return to 1, position restarts, sum memories are not cleared.
`timescale 1ns / 1ps
module box_filter_image_downscale import bfd_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int CHANNELS   = DEF_CHANNELS
) (
    input  logic       clk,
    input  logic       rst_n,
    bfd_in_if.sink     pix_in,
    bfd_cfg_if.sink    cfg,
    bfd_out_if.source  pix_out
);
    logic  q_push, q_full, q_pop, q_empty;
    item_t q_in, q_head;

    bfd_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .pix_in (pix_in),
        .cfg    (cfg),
        .q_push (q_push),
        .q_item (q_in),
        .q_full (q_full)
    );

    bfd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    bfd_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .CHANNELS  (CHANNELS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_head  (q_head),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .pix_out (pix_out)
    );
endmodule
